// File: design/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants for the nearest palette color search
// Palette geometry, field widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package npc_pkg;

	localparam int PAL_DEPTH = 256;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);
	localparam int COMP_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int SQ_W      = 2 * BYTE_W;
	localparam int DIST_W    = 18;
	localparam int CNT_W     = 9;
	localparam int IDX_W     = 8;
	localparam int COLOR_W   = 3 * COMP_W;

	localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(256);
	localparam logic [DIST_W-1:0] DIST_BOUND = DIST_W'(3 * 256 * 256 + 10);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              wr_en;
		logic              start;
		logic              rd_en;
		logic [PAL_AW-1:0] rd_addr;
		logic              load_out;
	} npc_cmd_t;

	typedef struct packed {
		logic [PAL_AW-1:0] last_addr;
		logic              pipe_busy;
		logic              out_full;
	} npc_stat_t;

endpackage

// File: design/npc_ctrl.sv
// ----------------------------------------------------------------------------
// npc_ctrl: search controller
// Accepts requests, sequences the palette scan addresses, waits for the
// distance pipeline to drain and hands the result to the output register.
// ----------------------------------------------------------------------------
module npc_ctrl
	import npc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      operation,
	input  logic      out_ready,
	input  npc_stat_t stat,
	output npc_cmd_t  cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [PAL_AW-1:0] addr_q;
	logic [PAL_AW-1:0] last_q;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd          = '0;
		cmd.wr_en    = accept && (operation == OP_WRITE);
		cmd.start    = accept && (operation == OP_QUERY);
		cmd.rd_en    = (state_q == ST_SCAN);
		cmd.rd_addr  = addr_q;
		cmd.load_out = (state_q == ST_DONE) && (!stat.out_full || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			last_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						addr_q  <= '0;
						last_q  <= stat.last_addr;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == last_q) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + PAL_AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!stat.pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (cmd.load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/npc_datapath.sv
// ----------------------------------------------------------------------------
// npc_datapath: palette memory and distance pipeline
// Holds the palette and the entry count, computes squared distances over
// the top byte of each component, tracks the best entry and registers the
// result.
// ----------------------------------------------------------------------------
module npc_datapath
	import npc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  npc_cmd_t            cmd,
	output npc_stat_t           stat,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    cfg_wdata,
	input  logic [IDX_W-1:0]    entry_index,
	input  logic [COMP_W-1:0]   red,
	input  logic [COMP_W-1:0]   green,
	input  logic [COMP_W-1:0]   blue,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [IDX_W-1:0]    nearest_index,
	output logic [COMP_W-1:0]   nearest_red,
	output logic [COMP_W-1:0]   nearest_green,
	output logic [COMP_W-1:0]   nearest_blue,
	output logic [DIST_W-1:0]   best_distance
);

	logic [COLOR_W-1:0] mem [PAL_DEPTH];

	logic [CNT_W-1:0]   entries_q;
	logic [BYTE_W-1:0]  qr_q, qg_q, qb_q;

	logic               v_s1;
	logic [PAL_AW-1:0]  idx_s1;
	logic [COLOR_W-1:0] color_s1;

	logic               v_s2;
	logic [PAL_AW-1:0]  idx_s2;
	logic [COLOR_W-1:0] color_s2;
	logic [SQ_W-1:0]    sqr_s2, sqg_s2, sqb_s2;

	logic [DIST_W-1:0]  best_d_q;
	logic [PAL_AW-1:0]  best_i_q;
	logic [COLOR_W-1:0] best_c_q;

	logic               out_valid_q;
	logic [IDX_W-1:0]   out_idx_q;
	logic [COLOR_W-1:0] out_color_q;
	logic [DIST_W-1:0]  out_dist_q;

	logic [BYTE_W-1:0]  dr, dg, db;
	logic [DIST_W-1:0]  cur_dist;

	function automatic logic [BYTE_W-1:0] abs_diff(input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	always_comb begin
		if (entries_q == '0) begin
			stat.last_addr = '0;
		end else if (int'(entries_q) >= PAL_DEPTH) begin
			stat.last_addr = PAL_AW'(PAL_DEPTH - 1);
		end else begin
			stat.last_addr = PAL_AW'(entries_q - CNT_W'(1));
		end
		stat.pipe_busy = v_s1 || v_s2;
		stat.out_full  = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= CNT_RESET;
		end else if (cfg_we) begin
			entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (int'(entry_index) < PAL_DEPTH)) begin
			mem[PAL_AW'(entry_index)] <= {red, green, blue};
		end
		if (cmd.rd_en) begin
			color_s1 <= mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qr_q <= red[COMP_W-1 -: BYTE_W];
			qg_q <= green[COMP_W-1 -: BYTE_W];
			qb_q <= blue[COMP_W-1 -: BYTE_W];
		end
		idx_s1 <= cmd.rd_addr;
	end

	assign dr = abs_diff(qr_q, color_s1[3*COMP_W-1 -: BYTE_W]);
	assign dg = abs_diff(qg_q, color_s1[2*COMP_W-1 -: BYTE_W]);
	assign db = abs_diff(qb_q, color_s1[COMP_W-1 -: BYTE_W]);

	always_ff @(posedge clk) begin
		sqr_s2   <= SQ_W'(dr) * SQ_W'(dr);
		sqg_s2   <= SQ_W'(dg) * SQ_W'(dg);
		sqb_s2   <= SQ_W'(db) * SQ_W'(db);
		idx_s2   <= idx_s1;
		color_s2 <= color_s1;
	end

	assign cur_dist = DIST_W'(sqr_s2) + DIST_W'(sqg_s2) + DIST_W'(sqb_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_d_q <= DIST_BOUND;
			best_i_q <= '0;
		end else if (v_s2 && (cur_dist < best_d_q)) begin
			best_d_q <= cur_dist;
			best_i_q <= idx_s2;
			best_c_q <= color_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_idx_q   <= IDX_W'(best_i_q);
			out_color_q <= best_c_q;
			out_dist_q  <= best_d_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign nearest_index = out_idx_q;
	assign nearest_red   = out_color_q[3*COMP_W-1 -: COMP_W];
	assign nearest_green = out_color_q[2*COMP_W-1 -: COMP_W];
	assign nearest_blue  = out_color_q[COMP_W-1 -: COMP_W];
	assign best_distance = out_dist_q;

endmodule

// File: design/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color: nearest color search over a 256-entry palette
//
// Input channel (in_valid/in_ready): operation 0 writes red/green/blue into
// palette entry entry_index and yields no result. Operation 1 queries
// red/green/blue and yields one result on the output channel
// (out_valid/out_ready): the lowest-index entry with the least squared
// distance over the top byte of each component, its stored color and
// that distance.
// A query scans entries 0 .. N-1, N being cfg_wdata last written (0 acts as
// 1, above 256 as 256), one palette read per cycle. After the scan the
// distance pipeline drains; the result becomes valid in the same cycle as
// in_ready returns, so a query holds the input until its result is loaded.
// Write cfg_we/cfg_wdata only while no request is in flight.
// Reset sets N to 256 and empties the output register; palette contents
// are undefined until written. A query must read only written entries.
// A result held by a stalled receiver does not block further writes or the
// next scan; a finished scan waits until the output register is free.
// ----------------------------------------------------------------------------
module nearest_palette_color
	import npc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [COMP_W-1:0] red,
	input  logic [COMP_W-1:0] green,
	input  logic [COMP_W-1:0] blue,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  nearest_index,
	output logic [COMP_W-1:0] nearest_red,
	output logic [COMP_W-1:0] nearest_green,
	output logic [COMP_W-1:0] nearest_blue,
	output logic [DIST_W-1:0] best_distance
);

	npc_cmd_t  cmd;
	npc_stat_t stat;

	npc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	npc_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.entry_index   (entry_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.nearest_index (nearest_index),
		.nearest_red   (nearest_red),
		.nearest_green (nearest_green),
		.nearest_blue  (nearest_blue),
		.best_distance (best_distance)
	);

endmodule

// File: tb/sv/palette_match_checker.sv
// ----------------------------------------------------------------------------
// palette_match_checker: prediction and comparison for nearest_palette_color
// Watches the register port and both channels. Keeps its own copy of the
// palette and of the searched entry count. Works out the closest entry for
// every accepted query, and compares each accepted result with the oldest
// prediction, field by field. Hands the mismatch count and the number of
// predictions still waiting to the testbench top.
// ----------------------------------------------------------------------------
module palette_match_checker
	import npc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              operation,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic [COMP_W-1:0] red,
	input  logic [COMP_W-1:0] green,
	input  logic [COMP_W-1:0] blue,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [IDX_W-1:0]  nearest_index,
	input  logic [COMP_W-1:0] nearest_red,
	input  logic [COMP_W-1:0] nearest_green,
	input  logic [COMP_W-1:0] nearest_blue,
	input  logic [DIST_W-1:0] best_distance,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
	} shade_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [COMP_W-1:0] r;
		logic [COMP_W-1:0] g;
		logic [COMP_W-1:0] b;
		logic [DIST_W-1:0] sq_dist;
	} match_t;

	shade_t           palette_copy [PAL_DEPTH];
	logic [CNT_W-1:0] entry_limit;
	match_t           awaited_matches [$];
	int               mismatches = 0;
	int               served = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic int unsigned top_byte_sq(input logic [COMP_W-1:0] a,
			input logic [COMP_W-1:0] b);
		int unsigned x;
		int unsigned y;
		int unsigned d;
		x = a[COMP_W-1 -: BYTE_W];
		y = b[COMP_W-1 -: BYTE_W];
		d = (x >= y) ? x - y : y - x;
		return d * d;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		int unsigned span;
		int unsigned total;
		int unsigned least;
		int unsigned winner;
		match_t      want;
		if (!arst_n) begin
			foreach (palette_copy[i])
				palette_copy[i] = '0;
			entry_limit = CNT_RESET;
			awaited_matches.delete();
			pending <= 0;
			errors <= mismatches;
		end else begin
			if (cfg_we)
				entry_limit = cfg_wdata;
			if (out_valid && out_ready) begin
				if (awaited_matches.size() == 0) begin
					report_mismatch($sformatf("result with no query waiting: index %0d",
						nearest_index));
				end else begin
					want = awaited_matches.pop_front();
					if (nearest_index !== want.index)
						report_mismatch($sformatf("query %0d nearest_index got %h want %h",
							served, nearest_index, want.index));
					if (nearest_red !== want.r)
						report_mismatch($sformatf("query %0d nearest_red got %h want %h",
							served, nearest_red, want.r));
					if (nearest_green !== want.g)
						report_mismatch($sformatf("query %0d nearest_green got %h want %h",
							served, nearest_green, want.g));
					if (nearest_blue !== want.b)
						report_mismatch($sformatf("query %0d nearest_blue got %h want %h",
							served, nearest_blue, want.b));
					if (best_distance !== want.sq_dist)
						report_mismatch($sformatf("query %0d best_distance got %0d want %0d",
							served, best_distance, want.sq_dist));
				end
				served++;
			end
			if (in_valid && in_ready) begin
				if (operation == OP_WRITE) begin
					palette_copy[entry_index] = '{red, green, blue};
				end else begin
					span = entry_limit;
					if (span == 0)
						span = 1;
					if (span > PAL_DEPTH)
						span = PAL_DEPTH;
					least = DIST_BOUND;
					winner = 0;
					for (int k = 0; k < span; k++) begin
						total = top_byte_sq(red, palette_copy[k].r)
							+ top_byte_sq(green, palette_copy[k].g)
							+ top_byte_sq(blue, palette_copy[k].b);
						if (total < least) begin
							least = total;
							winner = k;
						end
					end
					want.index = winner[IDX_W-1:0];
					want.r = palette_copy[winner].r;
					want.g = palette_copy[winner].g;
					want.b = palette_copy[winner].b;
					want.sq_dist = least[DIST_W-1:0];
					awaited_matches.push_back(want);
				end
			end
			pending <= awaited_matches.size();
			errors <= mismatches;
		end
	end

endmodule

// File: tb/sv/nearest_palette_color_test.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_test: testbench top for nearest_palette_color
// Drives palette writes and color queries over the request channel with
// random gaps, drains results with random stalls and two long hold-offs,
// and steps the searched entry count through small, large and out-of-range
// settings. A directed opening covers extreme colors, ties and the largest
// distance; random phases follow once the whole palette is written.
// ----------------------------------------------------------------------------
module nearest_palette_color_test;
	import npc_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CNT_W-1:0]  cfg_wdata;
	logic              in_valid;
	logic              in_ready;
	logic              operation;
	logic [IDX_W-1:0]  entry_index;
	logic [COMP_W-1:0] red;
	logic [COMP_W-1:0] green;
	logic [COMP_W-1:0] blue;
	logic              out_valid;
	logic              out_ready;
	logic [IDX_W-1:0]  nearest_index;
	logic [COMP_W-1:0] nearest_red;
	logic [COMP_W-1:0] nearest_green;
	logic [COMP_W-1:0] nearest_blue;
	logic [DIST_W-1:0] best_distance;
	int                errors;
	int                pending;
	bit                steady = 1'b0;
	int                sent = 0;

	nearest_palette_color u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.entry_index   (entry_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.nearest_index (nearest_index),
		.nearest_red   (nearest_red),
		.nearest_green (nearest_green),
		.nearest_blue  (nearest_blue),
		.best_distance (best_distance)
	);

	palette_match_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.entry_index   (entry_index),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.nearest_index (nearest_index),
		.nearest_red   (nearest_red),
		.nearest_green (nearest_green),
		.nearest_blue  (nearest_blue),
		.best_distance (best_distance),
		.errors        (errors),
		.pending       (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [COMP_W-1:0] draw_component();
		case ($urandom_range(0, 3))
			0: return {8'h00, 8'($urandom)};
			1: return {8'hff, 8'($urandom)};
			2: return {2'($urandom_range(0, 3)), 6'b0, 8'($urandom)};
			default: return COMP_W'($urandom);
		endcase
	endfunction

	task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
			input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
			input logic [COMP_W-1:0] b);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		entry_index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic set_entries(input logic [CNT_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [CNT_W-1:0] span;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		operation <= OP_WRITE;
		entry_index <= '0;
		red <= '0;
		green <= '0;
		blue <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_entries(4);
		send_request(OP_WRITE, 0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_WRITE, 1, 16'hffff, 16'hffff, 16'hffff);
		send_request(OP_WRITE, 2, 16'h00ff, 16'hff00, 16'h8000);
		send_request(OP_WRITE, 3, 16'h00ff, 16'h00ff, 16'h00ff);
		send_request(OP_WRITE, 255, 16'h1234, 16'h5678, 16'h9abc);
		send_request(OP_QUERY, 0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_QUERY, 8'hff, 16'hffff, 16'hffff, 16'hffff);
		send_request(OP_QUERY, 8'h5a, 16'h00ff, 16'hff00, 16'h80ff);
		send_request(OP_QUERY, 0, 16'h8000, 16'h8000, 16'h8000);
		send_request(OP_QUERY, 0, 16'h7fff, 16'h7fff, 16'h7fff);
		// entry count zero still searches entry 0; far corner gives the largest distance
		set_entries(0);
		send_request(OP_QUERY, 0, 16'hffff, 16'hffff, 16'hffff);
		send_request(OP_WRITE, 0, 16'h00ff, 16'h00ff, 16'h00ff);
		send_request(OP_QUERY, 0, 16'hffff, 16'h0000, 16'hffff);
		set_entries(1);
		send_request(OP_QUERY, 0, 16'h0000, 16'hffff, 16'h0000);
		set_entries(2);
		send_request(OP_QUERY, 0, 16'h80ff, 16'h80ff, 16'h80ff);

		set_entries(511);
		for (int k = 0; k < PAL_DEPTH; k++)
			send_request(OP_WRITE, IDX_W'(k), draw_component(), draw_component(),
				draw_component());

		while (sent < 1250) begin
			case ($urandom_range(0, 6))
				0: span = 1;
				1: span = 256;
				2: span = 511;
				3: span = CNT_W'($urandom_range(2, 16));
				4: span = CNT_W'($urandom_range(17, 255));
				5: span = CNT_W'($urandom_range(257, 511));
				default: span = CNT_W'($urandom_range(2, 32));
			endcase
			set_entries(span);
			steady = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(30, 90)) begin
				if ($urandom_range(0, 99) < 55)
					send_request(OP_QUERY, 8'($urandom), draw_component(),
						draw_component(), draw_component());
				else
					send_request(OP_WRITE, 8'($urandom), draw_component(),
						draw_component(), draw_component());
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : drain
		int unsigned stall;
		int unsigned taken;
		taken = 0;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 5);
			// hold off long enough for the block to fill and stall requests
			if (taken == 40 || taken == 300)
				stall = 2000;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	initial begin : watchdog
		#15_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
